/* rtl/core/msl_pkg.sv */
// Shared types and constants for the multi-channel servo slew limiter.
package msl_pkg;

  // Channel count and the width of a channel index
  localparam int CHANNELS = 16;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Pulse limits in microseconds
  localparam logic [11:0] PULSE_MIN = 12'd500;
  localparam logic [11:0] PULSE_MAX = 12'd2500;

  // Command codes
  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_OFF   = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_PULSE  = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  // Status codes
  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_BAD = 1'b1;

  // One channel entry of the state memory
  typedef struct packed {
    logic [11:0] cur;
    logic [11:0] tgt;
    logic [10:0] step;
  } chan_rec_t;

  // One result beat before it enters the output register
  typedef struct packed {
    logic [1:0]  kind;
    logic        status;
    logic [4:0]  channel;
    logic [11:0] drive;
    logic [11:0] target;
    logic        active;
    logic        moving;
    logic        last;
  } result_t;

endpackage

/* rtl/core/multi_channel_servo_slew_limiter.sv */
// Top level: per-channel servo pulse slew limiter with a memory-held channel table.
// Usage:
//   Commands enter on the s_axis channel (set target, turn off, tick, query), one
//   beat each. Results leave on the m_axis channel; tlast marks the final result
//   beat of a command. Set target and turn off give a pulse write (set target only
//   when the channel was inactive) and a status beat; query gives one reply beat;
//   a channel at or above the channel count gives one error status beat. Tick gives
//   a pulse write per moved channel in ascending order, then a done beat.
// Timing:
//   Channel current/target/step live in a table with one write and one registered
//   read port. A command is accepted and then issues its result beats in turn, the
//   table read being done together with the accept.
//   A tick walks the channels in ascending order, reading one entry per cycle except
//   while a moved channel waits for a full output register, then gives the done beat.
//   A new command is taken only once the previous one has issued all its results.
// Reset: clears all active flags and the control state and holds s_axis_tready low;
//   table contents stay undefined until a channel is first activated.
// Stall: a result waits in the output register while tready is low, and the
//   sequencer holds its next result until that register is free.
module multi_channel_servo_slew_limiter
  import msl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] channel, [16:5] requested_us, [27:17] step_us, [31:28] zero
  input  logic [31:0] s_axis_tdata,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] status, [5:1] out_channel, [17:6] drive_us, [29:18] target_us,
  // [30] is_active, [31] is_moving
  output logic [31:0] m_axis_tdata,
  // [1:0] kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_STAT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]      state, state_next;
  logic [1:0]      cmd;
  logic [4:0]      ch;
  logic            ch_ok;
  logic [11:0]     req;
  logic [10:0]     step;
  logic [CH_W-1:0] idx, idx_next;
  logic [CHANNELS-1:0] active, active_next;

  chan_rec_t       mem [CHANNELS];
  chan_rec_t       rd_data;
  chan_rec_t       wr_rec;
  logic            wr_en;

  result_t         res;
  logic            emit;
  logic            out_free;
  logic            accept;

  // Clamped pulse and slew step toward target
  logic [11:0]     pulse;
  logic [12:0]     up_sum;
  logic [11:0]     down_diff;
  logic [11:0]     next_cur;
  logic            moving;

  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign pulse = (req < PULSE_MIN) ? PULSE_MIN : ((req > PULSE_MAX) ? PULSE_MAX : req);

  assign moving    = active[idx] && (rd_data.cur != rd_data.tgt);
  assign up_sum    = {1'b0, rd_data.cur} + {2'b00, rd_data.step};
  assign down_diff = rd_data.cur - rd_data.tgt;

  always_comb begin
    if (rd_data.step == 11'd0) begin
      next_cur = rd_data.tgt;
    end else if (rd_data.cur < rd_data.tgt) begin
      next_cur = (up_sum < {1'b0, rd_data.tgt}) ? up_sum[11:0] : rd_data.tgt;
    end else begin
      next_cur = (down_diff > {1'b0, rd_data.step}) ?
                 (rd_data.cur - {1'b0, rd_data.step}) : rd_data.tgt;
    end
  end

  // Sequencer: next state, table write and result beat
  always_comb begin
    state_next  = state;
    idx_next    = idx;
    active_next = active;
    wr_en       = 1'b0;
    wr_rec      = rd_data;
    emit        = 1'b0;
    res         = '0;
    res.channel = ch;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOK;
          idx_next   = (s_axis_tuser == CMD_TICK) ? '0 : s_axis_tdata[CH_W-1:0];
        end
      end
      ST_LOOK: begin
        if (cmd == CMD_TICK) begin
          res.kind    = KIND_PULSE;
          res.channel = 5'(idx);
          res.drive   = next_cur;
          if (!moving || out_free) begin
            emit       = moving;
            wr_en      = moving;
            wr_rec.cur = next_cur;
            if (idx == CH_W'(CHANNELS - 1)) begin
              state_next = ST_DONE;
            end else begin
              idx_next = idx + 1'b1;
            end
          end
        end else if (!ch_ok) begin
          res.kind   = KIND_STATUS;
          res.status = STAT_BAD;
          res.last   = 1'b1;
          if (out_free) begin
            emit       = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (out_free) begin
          emit = 1'b1;
          case (cmd)
            CMD_SET: begin
              if (!active[idx]) begin
                res.kind         = KIND_PULSE;
                res.drive        = pulse;
                active_next[idx] = 1'b1;
                wr_en            = 1'b1;
                wr_rec.cur       = pulse;
                wr_rec.tgt       = pulse;
                wr_rec.step      = '0;
                state_next       = ST_STAT;
              end else begin
                res.kind    = KIND_STATUS;
                res.last    = 1'b1;
                wr_en       = 1'b1;
                wr_rec.tgt  = pulse;
                wr_rec.step = step;
                state_next  = ST_IDLE;
              end
            end
            CMD_OFF: begin
              res.kind         = KIND_PULSE;
              active_next[idx] = 1'b0;
              state_next       = ST_STAT;
            end
            default: begin
              res.kind   = KIND_QUERY;
              res.drive  = rd_data.cur;
              res.target = rd_data.tgt;
              res.active = active[idx];
              res.moving = moving;
              res.last   = 1'b1;
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_STAT: begin
        res.kind = KIND_STATUS;
        res.last = 1'b1;
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        res.kind    = KIND_DONE;
        res.channel = '0;
        res.last    = 1'b1;
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // Channel table: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx] <= wr_rec;
    end
    rd_data <= mem[idx_next];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      active <= '0;
      idx    <= '0;
    end else begin
      state  <= state_next;
      active <= active_next;
      idx    <= idx_next;
    end
  end

  // Command capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd   <= s_axis_tuser;
      ch    <= s_axis_tdata[4:0];
      req   <= s_axis_tdata[16:5];
      step  <= s_axis_tdata[27:17];
      ch_ok <= ({1'b0, s_axis_tdata[4:0]} < 6'(CHANNELS));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= {res.moving, res.active, res.target, res.drive, res.channel,
                       res.status};
      m_axis_tuser <= res.kind;
      m_axis_tlast <= res.last;
    end
  end

  // Tick walks channels one by one in ascending order
  a_tick_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOK && cmd == CMD_TICK && idx != CH_W'(CHANNELS - 1) &&
     (!moving || out_free)) |=> (idx == $past(idx) + 1'b1))
    else $error("tick walk skipped or repeated a channel");

  // Activating set leaves the channel active
  a_set_active: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOK && cmd == CMD_SET && ch_ok && out_free) |=> active[$past(idx)])
    else $error("set target did not leave channel active");

  // The last result of a command returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && res.last) |=> (state == ST_IDLE))
    else $error("sequencer busy after final result");

  // An emitted beat never overwrites an unaccepted one
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result issued while output register held");

  // An accepted command goes straight to the table lookup
  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_LOOK))
    else $error("accepted command did not start lookup");

endmodule
